/* hdl/vector_display_list_processor_defines.svh */
// Assertion macros used by the checker of the vector display-list processor.
`ifndef VECTOR_DISPLAY_LIST_PROCESSOR_DEFINES_SVH
`define VECTOR_DISPLAY_LIST_PROCESSOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define VDLP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define VDLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/vdlp_pkg.sv */
// Types, codes and defaults shared by the vector display-list processor files.
package vdlp_pkg;

   // Default configuration of the top level.
   localparam int DEF_STACK_DEPTH   = 4;
   localparam int DEF_POSITION_BITS = 24;
   localparam int DEF_PC_BITS       = 13;

   // Fixed widths of the result fields.
   localparam int POS_OUT_BITS = 24;
   localparam int PC_OUT_BITS  = 13;

   // Beam home position and the vertical origin of absolute moves.
   localparam int BEAM_X_HOME  = 1023 * 8192;
   localparam int BEAM_Y_HOME  = 512 * 8192;
   localparam int ABS_Y_ORIGIN = 896;

   // Commands.
   localparam logic CMD_EXEC  = 1'b0;
   localparam logic CMD_FRAME = 1'b1;

   // Opcodes. Everything up to OP_LVEC_LAST is a long vector.
   localparam logic [3:0] OP_LVEC_LAST = 4'd9;
   localparam logic [3:0] OP_ABS       = 4'd10;
   localparam logic [3:0] OP_HALT      = 4'd11;
   localparam logic [3:0] OP_CALL      = 4'd12;
   localparam logic [3:0] OP_RET       = 4'd13;
   localparam logic [3:0] OP_JUMP      = 4'd14;
   localparam logic [3:0] OP_SVEC      = 4'd15;

   // Fault codes.
   localparam logic [1:0] FAULT_NONE      = 2'd0;
   localparam logic [1:0] FAULT_OVERFLOW  = 2'd1;
   localparam logic [1:0] FAULT_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic        command;
      logic [15:0] first_word;
      logic [15:0] second_word;
   } vdlp_req_type;

   typedef struct packed {
      logic                           draw;
      logic signed [POS_OUT_BITS-1:0] from_x;
      logic signed [POS_OUT_BITS-1:0] from_y;
      logic signed [POS_OUT_BITS-1:0] to_x;
      logic signed [POS_OUT_BITS-1:0] to_y;
      logic [3:0]                     brightness;
      logic [PC_OUT_BITS-1:0]         next_pc;
      logic                           halted;
      logic [1:0]                     fault;
   } vdlp_rsp_type;

endpackage

/* hdl/vector_display_list_processor.sv */
// Top level of the vector display-list processor: decode, beam update and result buffer.
//
// The req channel carries one display-list instruction per item: a command bit, the
// first instruction word and the second word (used by long vectors and absolute moves).
// A command of one starts a new frame instead: counter, stack pointer, scale, stop flag
// and fault go back to zero and the beam returns home; no instruction is executed.
// The rsp channel returns exactly one item per request: the segment drawn (if any),
// the next fetch address, and the halted and fault status.
//
// One item is accepted every cycle while req_stall is low. Decode, the variable shift
// of the delta and the 24-bit beam add all sit in the single register-to-register path
// from the req port to the result register (or the skid register while rsp is held).
//
// The result register is backed by a one-item skid register. When the receiver
// stalls, the next item is still accepted and parked in the skid register; req_stall
// rises only while the skid register is full, so it is driven from a flop alone.
//
// Reset is synchronous and puts the block in the same state as a frame start, with
// both result buffers empty. The return stack is not cleared; returning to an entry
// that was never written gives an undefined address.
module vector_display_list_processor #(
   parameter int STACK_DEPTH   = vdlp_pkg::DEF_STACK_DEPTH,
   parameter int POSITION_BITS = vdlp_pkg::DEF_POSITION_BITS,
   parameter int PC_BITS       = vdlp_pkg::DEF_PC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  vdlp_pkg::vdlp_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output vdlp_pkg::vdlp_rsp_type rsp_data
);

   localparam int SP_W = $clog2(STACK_DEPTH);
   localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);
   localparam logic [POSITION_BITS-1:0] BEAM_X_RESET = POSITION_BITS'(vdlp_pkg::BEAM_X_HOME);
   localparam logic [POSITION_BITS-1:0] BEAM_Y_RESET = POSITION_BITS'(vdlp_pkg::BEAM_Y_HOME);

   // Architectural state.
   logic [PC_BITS-1:0]       pc_ff, pc_in;
   logic [SP_W-1:0]          sp_ff, sp_in;
   logic [PC_BITS-1:0]       stack_ff [STACK_DEPTH];
   logic [3:0]               scale_ff, scale_in;
   logic [POSITION_BITS-1:0] beam_x_ff, beam_x_in;
   logic [POSITION_BITS-1:0] beam_y_ff, beam_y_in;
   logic                     stopped_ff, stopped_in;
   logic [1:0]               fault_ff, fault_in;

   // Result buffer: output register plus one skid entry.
   logic                   rsp_valid_ff;
   vdlp_pkg::vdlp_rsp_type rsp_data_ff;
   logic                   skid_valid_ff;
   vdlp_pkg::vdlp_rsp_type skid_data_ff;

   logic                   req_accept;
   logic                   rsp_ready;
   logic                   stack_we;
   logic [PC_BITS-1:0]     pc_inc;
   vdlp_pkg::vdlp_rsp_type rsp_in;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_ready  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Decode and execute one instruction against the current state.
   always_comb begin
      logic [3:0]               op;
      logic [15:0]              w1;
      logic [15:0]              w2;
      logic                     is_long;
      logic                     is_short;
      logic                     run;
      logic [9:0]               dx_mag;
      logic [9:0]               dy_mag;
      logic                     dx_neg;
      logic                     dy_neg;
      logic [3:0]               z;
      logic [3:0]               s;
      logic [3:0]               cnt;
      logic [3:0]               sh;
      logic signed [10:0]       dx_val;
      logic signed [10:0]       dy_val;
      logic signed [10:0]       dx_del;
      logic signed [10:0]       dy_del;
      logic [POSITION_BITS-1:0] vec_x;
      logic [POSITION_BITS-1:0] vec_y;
      logic [PC_BITS-1:0]       target;

      w1 = req_data.first_word;
      w2 = req_data.second_word;
      op = w1[15:12];
      is_long  = (op <= vdlp_pkg::OP_LVEC_LAST);
      is_short = (op == vdlp_pkg::OP_SVEC);
      run      = (req_data.command == vdlp_pkg::CMD_EXEC) && !stopped_ff;

      // Delta fields of the two vector formats.
      if (is_short) begin
         dy_mag = {w1[9:8], 8'b0};
         dy_neg = w1[10];
         dx_mag = {w1[1:0], 8'b0};
         dx_neg = w1[2];
         z      = w1[7:4];
         s      = 4'd2 + {2'b0, w1[3], w1[11]};
      end else begin
         dy_mag = w1[9:0];
         dy_neg = w1[10];
         dx_mag = w2[9:0];
         dx_neg = w2[10];
         z      = w2[15:12];
         s      = op;
      end

      // A count above nine acts as minus one, which shifts by ten.
      cnt = scale_ff + s;
      sh  = (cnt > 4'd9) ? 4'd10 : 4'd9 - cnt;
      dx_val = dx_neg ? -$signed({1'b0, dx_mag}) : $signed({1'b0, dx_mag});
      dy_val = dy_neg ? -$signed({1'b0, dy_mag}) : $signed({1'b0, dy_mag});
      dx_del = dx_val >>> sh;
      dy_del = dy_val >>> sh;
      vec_x  = beam_x_ff + POSITION_BITS'(dx_del);
      vec_y  = beam_y_ff - POSITION_BITS'(dy_del);

      pc_inc = pc_ff + ((op <= vdlp_pkg::OP_ABS) ? PC_BITS'(2) : PC_BITS'(1));
      target = PC_BITS'(w1[11:0]);

      pc_in      = pc_ff;
      sp_in      = sp_ff;
      scale_in   = scale_ff;
      beam_x_in  = beam_x_ff;
      beam_y_in  = beam_y_ff;
      stopped_in = stopped_ff;
      fault_in   = fault_ff;
      stack_we   = 1'b0;

      rsp_in = '0;

      if (req_data.command == vdlp_pkg::CMD_FRAME) begin
         pc_in      = '0;
         sp_in      = '0;
         scale_in   = '0;
         beam_x_in  = BEAM_X_RESET;
         beam_y_in  = BEAM_Y_RESET;
         stopped_in = 1'b0;
         fault_in   = vdlp_pkg::FAULT_NONE;
      end else if (run) begin
         pc_in = pc_inc;
         if (is_long || is_short) begin
            beam_x_in = vec_x;
            beam_y_in = vec_y;
            if (z != 4'd0) begin
               rsp_in.draw       = 1'b1;
               rsp_in.from_x     = vdlp_pkg::POS_OUT_BITS'($signed(beam_x_ff));
               rsp_in.from_y     = vdlp_pkg::POS_OUT_BITS'($signed(beam_y_ff));
               rsp_in.to_x       = vdlp_pkg::POS_OUT_BITS'($signed(vec_x));
               rsp_in.to_y       = vdlp_pkg::POS_OUT_BITS'($signed(vec_y));
               rsp_in.brightness = z;
            end
         end else begin
            case (op)
               vdlp_pkg::OP_ABS: begin
                  scale_in  = w2[15:12];
                  beam_x_in = POSITION_BITS'($signed(w2[11:0]));
                  beam_y_in = POSITION_BITS'(vdlp_pkg::ABS_Y_ORIGIN)
                              - POSITION_BITS'($signed(w1[11:0]));
               end
               vdlp_pkg::OP_HALT: begin
                  stopped_in = 1'b1;
               end
               vdlp_pkg::OP_CALL: begin
                  // The return address is stored even when the call overflows.
                  stack_we = 1'b1;
                  pc_in    = target;
                  if (sp_ff == SP_LAST) begin
                     stopped_in = 1'b1;
                     fault_in   = vdlp_pkg::FAULT_OVERFLOW;
                     sp_in      = '0;
                  end else begin
                     sp_in = sp_ff + SP_W'(1);
                  end
               end
               vdlp_pkg::OP_RET: begin
                  if (sp_ff == '0) begin
                     stopped_in = 1'b1;
                     fault_in   = vdlp_pkg::FAULT_UNDERFLOW;
                     sp_in      = SP_LAST;
                  end else begin
                     sp_in = sp_ff - SP_W'(1);
                  end
                  pc_in = stack_ff[sp_in];
               end
               vdlp_pkg::OP_JUMP: begin
                  pc_in = target;
               end
               default: begin
                  pc_in = pc_inc;
               end
            endcase
         end
      end

      rsp_in.next_pc = vdlp_pkg::PC_OUT_BITS'(pc_in);
      rsp_in.halted  = stopped_in;
      rsp_in.fault   = fault_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= '0;
         sp_ff      <= '0;
         scale_ff   <= '0;
         beam_x_ff  <= BEAM_X_RESET;
         beam_y_ff  <= BEAM_Y_RESET;
         stopped_ff <= 1'b0;
         fault_ff   <= vdlp_pkg::FAULT_NONE;
      end else if (req_accept) begin
         pc_ff      <= pc_in;
         sp_ff      <= sp_in;
         scale_ff   <= scale_in;
         beam_x_ff  <= beam_x_in;
         beam_y_ff  <= beam_y_in;
         stopped_ff <= stopped_in;
         fault_ff   <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && stack_we) begin
         stack_ff[sp_ff] <= pc_inc;
      end
   end

   // Skid buffer control. An item only enters the skid entry while the output is held.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : rsp_in;
      end else if (req_accept) begin
         skid_data_ff <= rsp_in;
      end
   end

endmodule

/* hdl/vdlp_checker.sv */
// Port-level checker for the vector display-list processor and its bind.
`include "vector_display_list_processor_defines.svh"

module vdlp_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input vdlp_pkg::vdlp_rsp_type rsp_data
);

   // The skid entry can only be full while a result is waiting at the output.
   `VDLP_ASSERT_NOW(a_stall_needs_result, clock, reset, req_stall, rsp_valid,
                    "req_stall without a pending result")

   // A latched fault always comes with the halted flag.
   `VDLP_ASSERT_NOW(a_fault_halts, clock, reset,
                    rsp_valid && (rsp_data.fault != vdlp_pkg::FAULT_NONE),
                    rsp_data.halted, "fault reported without halted")

   // A drawn segment carries a nonzero intensity.
   `VDLP_ASSERT_NOW(a_draw_bright, clock, reset, rsp_valid && rsp_data.draw,
                    rsp_data.brightness != 4'd0, "segment drawn with zero brightness")

   // Without a segment all segment fields are zero.
   `VDLP_ASSERT_NOW(a_blank_zero, clock, reset, rsp_valid && !rsp_data.draw,
                    (rsp_data.brightness == 4'd0) && (rsp_data.from_x == '0)
                    && (rsp_data.from_y == '0) && (rsp_data.to_x == '0)
                    && (rsp_data.to_y == '0), "blank result with segment data")

   // A stalled result stays offered and unchanged.
   `VDLP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_data), "stalled result dropped or changed")

endmodule

bind vector_display_list_processor vdlp_checker u_vdlp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* test/tb.sv */
// Self-checking testbench for the vector display-list processor: directed script, random programs.
`timescale 1ns / 1ps

module tb;
   import vdlp_pkg::*;

   // The run stops here whatever happens.
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int RANDOM_ITEMS = 1875;
   // Length of the one long receiver hold-off, in cycles.
   localparam int HOLD_CYCLES  = 60;
   // The first long-vector opcode; opcodes up to OP_LVEC_LAST are long vectors.
   localparam logic [3:0] OP_LVEC_FIRST = 4'd0;

   // One line of the directed script. Where typed is set, the result is written out by
   // hand: a status-only result with the given counter, halt flag and fault code.
   typedef struct packed {
      vdlp_req_type rq;
      logic         typed;
      logic [12:0]  pc;
      logic         halted;
      logic [1:0]   fault;
   } script_line_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   vdlp_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   vdlp_rsp_type rsp_data;

   // Own copy of the processor state, advanced once for every item the block accepts.
   logic [12:0] prog_ctr;
   int          stack_ptr;
   logic [12:0] return_addr [DEF_STACK_DEPTH];
   bit          entry_written [DEF_STACK_DEPTH];
   logic [3:0]  scale_reg;
   logic [23:0] beam_x;
   logic [23:0] beam_y;
   bit          is_stopped;
   logic [1:0]  fault_latch;

   // Results still owed by the block, oldest first.
   vdlp_rsp_type beam_updates [$];

   int mismatch_count = 0;
   int cycle_count;
   // Set by the stimulus, picked up by the receiver: one long hold-off, and the
   // final part of the run where neither side idles.
   bit hold_request = 1'b0;
   bit calm = 1'b0;

   always #5 clock = ~clock;

   vector_display_list_processor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A frame start clears the counter, stack pointer, scale, stop flag and fault, and
   // sends the beam home. The return stack keeps its contents.
   function automatic void frame_restart();
      prog_ctr    = '0;
      stack_ptr   = 0;
      scale_reg   = '0;
      beam_x      = BEAM_X_HOME[23:0];
      beam_y      = BEAM_Y_HOME[23:0];
      is_stopped  = 1'b0;
      fault_latch = FAULT_NONE;
   endfunction

   // Executes one instruction on the local state and returns the result it produces.
   function automatic vdlp_rsp_type execute_instruction(vdlp_req_type rq);
      logic [3:0]   op;
      logic [15:0]  w1;
      logic [15:0]  w2;
      int           dx;
      int           dy;
      int           sel;
      int           shift_cnt;
      logic [3:0]   bright;
      bit           vector_op;
      logic [23:0]  start_x;
      logic [23:0]  start_y;
      vdlp_rsp_type res;
      w1 = rq.first_word;
      w2 = rq.second_word;
      op = w1[15:12];
      res = '0;
      vector_op = 1'b0;
      dx = 0;
      dy = 0;
      sel = 0;
      bright = '0;
      if (rq.command == CMD_FRAME) begin
         frame_restart();
      end else if (!is_stopped) begin
         // Long vectors and absolute moves take two words, everything else one.
         prog_ctr = prog_ctr + ((op <= OP_ABS) ? 13'd2 : 13'd1);
         case (op)
            OP_SVEC: begin
               // Short vector: two-bit magnitudes in the high byte, scale from two bits.
               dy = int'(w1[9:8]) << 8;
               if (w1[10]) dy = -dy;
               dx = int'(w1[1:0]) << 8;
               if (w1[2]) dx = -dx;
               bright = w1[7:4];
               sel = 2 + (w1[3] ? 2 : 0) + int'(w1[11]);
               vector_op = 1'b1;
            end
            OP_ABS: begin
               scale_reg = w2[15:12];
               beam_x = 24'(int'(signed'(w2[11:0])));
               beam_y = 24'(ABS_Y_ORIGIN - int'(signed'(w1[11:0])));
            end
            OP_HALT: begin
               is_stopped = 1'b1;
            end
            OP_CALL: begin
               // The return address is stored even when the call overflows the stack.
               return_addr[stack_ptr] = prog_ctr;
               entry_written[stack_ptr] = 1'b1;
               if (stack_ptr == DEF_STACK_DEPTH - 1) begin
                  is_stopped = 1'b1;
                  fault_latch = FAULT_OVERFLOW;
                  stack_ptr = 0;
               end else begin
                  stack_ptr++;
               end
               prog_ctr = {1'b0, w1[11:0]};
            end
            OP_RET: begin
               // Underflow wraps the pointer to the top entry and still loads from it.
               if (stack_ptr == 0) begin
                  is_stopped = 1'b1;
                  fault_latch = FAULT_UNDERFLOW;
                  stack_ptr = DEF_STACK_DEPTH - 1;
               end else begin
                  stack_ptr--;
               end
               prog_ctr = return_addr[stack_ptr];
            end
            OP_JUMP: begin
               prog_ctr = {1'b0, w1[11:0]};
            end
            default: begin
               // Long vector: ten-bit magnitudes with a sign bit, the opcode is the scale.
               dy = int'(w1[9:0]);
               if (w1[10]) dy = -dy;
               dx = int'(w2[9:0]);
               if (w2[10]) dx = -dx;
               bright = w2[15:12];
               sel = int'(op);
               vector_op = 1'b1;
            end
         endcase
         if (vector_op) begin
            // A count above nine stands for minus one, so the shift reaches ten.
            shift_cnt = (int'(scale_reg) + sel) & 15;
            if (shift_cnt > 9) shift_cnt = -1;
            start_x = beam_x;
            start_y = beam_y;
            beam_x = beam_x + 24'(dx >>> (9 - shift_cnt));
            beam_y = beam_y - 24'(dy >>> (9 - shift_cnt));
            if (bright != 4'd0) begin
               res.draw       = 1'b1;
               res.from_x     = start_x;
               res.from_y     = start_y;
               res.to_x       = beam_x;
               res.to_y       = beam_y;
               res.brightness = bright;
            end
         end
      end
      res.next_pc = prog_ctr;
      res.halted  = is_stopped;
      res.fault   = fault_latch;
      return res;
   endfunction

   // Picks the next instruction from the current state. Most items form well-behaved
   // programs: vectors, absolute moves, jumps and balanced calls and returns, with halts
   // and stack overflows ended by a new frame. A few items are fully random words.
   function automatic vdlp_req_type pick_instruction();
      vdlp_req_type rq;
      int           roll;
      int           top;
      rq.command     = CMD_EXEC;
      rq.first_word  = 16'($urandom);
      rq.second_word = 16'($urandom);
      roll = $urandom_range(0, 99);
      if (is_stopped) begin
         // Mostly restart; the rest are ignored and only check that the block stays put.
         if (roll < 75) rq.command = CMD_FRAME;
      end else if (roll < 2) begin
         rq.command = CMD_FRAME;
      end else if (roll < 40) begin
         rq.first_word[15:12] = 4'($urandom_range(int'(OP_LVEC_FIRST), int'(OP_LVEC_LAST)));
      end else if (roll < 58) begin
         rq.first_word[15:12] = OP_SVEC;
      end else if (roll < 66) begin
         rq.first_word[15:12] = OP_ABS;
      end else if (roll < 69) begin
         rq.first_word[15:12] = OP_HALT;
      end else if (roll < 77) begin
         rq.first_word[15:12] = OP_CALL;
      end else if (roll < 86) begin
         rq.first_word[15:12] = OP_RET;
      end else if (roll < 91) begin
         rq.first_word[15:12] = OP_JUMP;
      end
      // A return must never load a stack entry that no call has written yet.
      if (rq.command == CMD_EXEC && !is_stopped && rq.first_word[15:12] == OP_RET) begin
         top = (stack_ptr == 0) ? DEF_STACK_DEPTH - 1 : stack_ptr - 1;
         if (!entry_written[top]) rq.first_word[15:12] = OP_JUMP;
      end
      return rq;
   endfunction

   // Compares one result from the block with the oldest one owed, field by field.
   function automatic void check_result(vdlp_rsp_type got, vdlp_rsp_type want);
      if (got.draw !== want.draw || got.from_x !== want.from_x ||
          got.from_y !== want.from_y || got.to_x !== want.to_x ||
          got.to_y !== want.to_y || got.brightness !== want.brightness ||
          got.next_pc !== want.next_pc || got.halted !== want.halted ||
          got.fault !== want.fault) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("mismatch: expected draw=%0d (%0d,%0d)->(%0d,%0d) z=%0d pc=%0d h=%0d f=%0d",
                     want.draw, want.from_x, want.from_y, want.to_x, want.to_y,
                     want.brightness, want.next_pc, want.halted, want.fault);
            $display("          actual   draw=%0d (%0d,%0d)->(%0d,%0d) z=%0d pc=%0d h=%0d f=%0d",
                     got.draw, got.from_x, got.from_y, got.to_x, got.to_y,
                     got.brightness, got.next_pc, got.halted, got.fault);
         end
      end
   endfunction

   // Offers one item and holds it until the block takes it. The state is advanced at the
   // edge of acceptance, so the next item is picked from the state this one leaves.
   task automatic issue(input vdlp_req_type rq, input logic typed, input vdlp_rsp_type typed_rsp);
      vdlp_rsp_type want;
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = execute_instruction(rq);
      beam_updates.push_back(typed ? typed_rsp : want);
   endtask

   // The sender now and then drops valid for a burst of cycles.
   task automatic sender_idle();
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Every result the block hands over is checked against the oldest one owed.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (beam_updates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result: pc=%0d", rsp_data.next_pc);
         end else begin
            check_result(rsp_data, beam_updates.pop_front());
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request so that the result
   // buffers fill and the block has to stall its input. No stalls in the calm phase.
   initial begin
      int held;
      rsp_stall <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[vector_display_list_processor] ERROR");
      $finish;
   end

   // Stimulus: reset, the directed script, then random programs.
   initial begin
      script_line_type script [25];
      vdlp_rsp_type    typed_rsp;
      vdlp_req_type    rq;
      int              useful;
      bit              was_live;
      bit              hold_done;
      bit              drain_done;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      frame_restart();

      // The directed script walks the extremes of every field and each special case.
      // Status-only rows with obvious outcomes carry their result by hand.
      script = '{
         // Frame start right after reset: everything at zero.
         '{{CMD_FRAME, 16'h0000, 16'h0000}, 1'b1, 13'h000, 1'b0, FAULT_NONE},
         // Long vectors with full-scale deltas of both signs at the lowest and
         // highest opcode, then one with zero delta and zero intensity.
         '{{CMD_EXEC, {OP_LVEC_FIRST, 12'h3FF}, 16'hF7FF}, 1'b0, 13'h0, 1'b0, FAULT_NONE},
         '{{CMD_EXEC, {OP_LVEC_LAST, 12'h7FF}, 16'h83FF}, 1'b0, 13'h0, 1'b0, FAULT_NONE},
         '{{CMD_EXEC, 16'h5000, 16'h0000}, 1'b0, 13'h0, 1'b0, FAULT_NONE},
         // Absolute move to the most negative y word and largest x, scale 15.
         '{{CMD_EXEC, {OP_ABS, 12'h800}, 16'hF7FF}, 1'b0, 13'h0, 1'b0, FAULT_NONE},
         // Scale wraps to a count above nine: the delta shrinks to 0 or -1.
         '{{CMD_EXEC, {OP_LVEC_FIRST, 12'h7FF}, 16'h13FF}, 1'b0, 13'h0, 1'b0, FAULT_NONE},
         '{{CMD_EXEC, {OP_ABS, 12'h7FF}, 16'h1800}, 1'b0, 13'h0, 1'b0, FAULT_NONE},
         '{{CMD_EXEC, {OP_LVEC_LAST, 12'h401}, 16'h2401}, 1'b0, 13'h0, 1'b0, FAULT_NONE},
         // Short vectors: everything set, nothing set, and a mixed pattern.
         '{{CMD_EXEC, {OP_SVEC, 12'hFFF}, 16'hFFFF}, 1'b0, 13'h0, 1'b0, FAULT_NONE},
         '{{CMD_EXEC, {OP_SVEC, 12'h000}, 16'h0000}, 1'b0, 13'h0, 1'b0, FAULT_NONE},
         '{{CMD_EXEC, {OP_SVEC, 12'h8F3}, 16'h5A5A}, 1'b0, 13'h0, 1'b0, FAULT_NONE},
         // Jump to the highest target, then halt one word later.
         '{{CMD_EXEC, {OP_JUMP, 12'hFFF}, 16'h0000}, 1'b0, 13'h0, 1'b0, FAULT_NONE},
         '{{CMD_EXEC, {OP_HALT, 12'h000}, 16'h0000}, 1'b1, 13'h1000, 1'b1, FAULT_NONE},
         // A vector while halted is ignored.
         '{{CMD_EXEC, 16'h0123, 16'hF456}, 1'b1, 13'h1000, 1'b1, FAULT_NONE},
         '{{CMD_FRAME, 16'hFFFF, 16'hFFFF}, 1'b1, 13'h000, 1'b0, FAULT_NONE},
         // Four nested calls: the last one overflows the stack and halts.
         '{{CMD_EXEC, {OP_CALL, 12'h123}, 16'h0000}, 1'b1, 13'h123, 1'b0, FAULT_NONE},
         '{{CMD_EXEC, {OP_CALL, 12'h234}, 16'h0000}, 1'b1, 13'h234, 1'b0, FAULT_NONE},
         '{{CMD_EXEC, {OP_CALL, 12'h345}, 16'h0000}, 1'b1, 13'h345, 1'b0, FAULT_NONE},
         '{{CMD_EXEC, {OP_CALL, 12'h456}, 16'h0000}, 1'b1, 13'h456, 1'b1, FAULT_OVERFLOW},
         '{{CMD_EXEC, {OP_HALT, 12'hFFF}, 16'h0000}, 1'b1, 13'h456, 1'b1, FAULT_OVERFLOW},
         '{{CMD_FRAME, 16'h0000, 16'h0000}, 1'b1, 13'h000, 1'b0, FAULT_NONE},
         // Return on an empty stack underflows and loads the top entry.
         '{{CMD_EXEC, {OP_RET, 12'h000}, 16'h0000}, 1'b1, 13'h346, 1'b1, FAULT_UNDERFLOW},
         '{{CMD_FRAME, 16'h0000, 16'h0000}, 1'b1, 13'h000, 1'b0, FAULT_NONE},
         // A plain call and return pair.
         '{{CMD_EXEC, {OP_CALL, 12'hFFF}, 16'hFFFF}, 1'b0, 13'h0, 1'b0, FAULT_NONE},
         '{{CMD_EXEC, {OP_RET, 12'hFFF}, 16'hFFFF}, 1'b0, 13'h0, 1'b0, FAULT_NONE}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         typed_rsp = '0;
         typed_rsp.next_pc = script[i].pc;
         typed_rsp.halted  = script[i].halted;
         typed_rsp.fault   = script[i].fault;
         issue(script[i].rq, script[i].typed, typed_rsp);
         sender_idle();
      end

      // Random programs. Items ignored while halted do not count toward the total.
      useful = 0;
      hold_done = 1'b0;
      drain_done = 1'b0;
      while (useful < RANDOM_ITEMS) begin
         calm = (useful >= RANDOM_ITEMS - 150);
         if (!hold_done && useful >= 400) begin
            // The receiver holds off for a long stretch while items keep coming.
            hold_request = 1'b1;
            hold_done = 1'b1;
         end
         if (!drain_done && useful >= 900) begin
            // The sender waits until every owed result has come back.
            drain_done = 1'b1;
            req_valid <= 1'b0;
            do @(posedge clock); while (beam_updates.size() != 0);
         end
         rq = pick_instruction();
         was_live = (rq.command == CMD_FRAME) || !is_stopped;
         issue(rq, 1'b0, '0);
         if (was_live) useful++;
         sender_idle();
      end
      req_valid <= 1'b0;

      // Let the last results drain, then keep watching for anything stray.
      while (beam_updates.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[vector_display_list_processor] OK");
      end else begin
         $display("[vector_display_list_processor] ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/vdlp_pkg.sv
hdl/vector_display_list_processor.sv
hdl/vdlp_checker.sv
test/tb.sv
